// ===== rtl/esd_pkg.sv =====
`default_nettype none

package esd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BODY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 2'd1;

  localparam logic [BYTE_W-1:0] SYNC_RESET   = 8'd255;
  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd253;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] index;
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] length;
    logic [BYTE_W-1:0] checksum;
    logic              in_progress;
  } esd_result_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    wdata;
  } esd_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/esd_decode.sv =====
`default_nettype none

module esd_decode import esd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire esd_cfg_t    cfg,
  input  wire logic        push,
  input  wire logic [BYTE_W-1:0] rx_byte,
  input  wire logic        q_full,
  output logic             q_push,
  output esd_result_t      q_data
);

  localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
  localparam logic [PHASE_W-1:0] PH_CMD  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_LEN  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_BODY = 3'd3;
  localparam logic [PHASE_W-1:0] PH_SUM  = 3'd4;

  logic [BYTE_W-1:0]  sync_r, escape_r;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic               esc_pend_r, esc_pend_nxt;
  logic [BYTE_W-1:0]  cmd_r, cmd_nxt;
  logic [BYTE_W-1:0]  len_r, len_nxt;
  logic [BYTE_W-1:0]  cnt_r, cnt_nxt;
  logic [BYTE_W-1:0]  cnt_inc;
  logic [BYTE_W-1:0]  ub;
  logic               accept;

  assign accept  = push && !q_full;
  assign q_push  = accept;
  assign cnt_inc = cnt_r + 8'd1;
  assign ub      = esc_pend_r ? (rx_byte + 8'd1) : rx_byte;

  always_comb begin
    phase_nxt    = phase_r;
    esc_pend_nxt = esc_pend_r;
    cmd_nxt      = cmd_r;
    len_nxt      = len_r;
    cnt_nxt      = cnt_r;
    q_data       = '0;
    unique case (phase_r)
      PH_CMD, PH_LEN, PH_BODY, PH_SUM: begin
        if (rx_byte == escape_r) begin
          esc_pend_nxt = 1'b1;
        end else begin
          esc_pend_nxt = 1'b0;
          unique case (phase_r)
            PH_CMD: begin
              cmd_nxt   = ub;
              phase_nxt = PH_LEN;
            end
            PH_LEN: begin
              len_nxt   = ub;
              cnt_nxt   = '0;
              phase_nxt = (ub == '0) ? PH_SUM : PH_BODY;
            end
            PH_BODY: begin
              q_data.kind  = KIND_BODY;
              q_data.data  = ub;
              q_data.index = cnt_r;
              cnt_nxt      = cnt_inc;
              if (cnt_inc == len_r) begin
                phase_nxt = PH_SUM;
              end
            end
            default: begin
              q_data.kind     = KIND_DONE;
              q_data.checksum = ub;
              phase_nxt       = PH_IDLE;
            end
          endcase
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (rx_byte == sync_r) begin
          phase_nxt = PH_CMD;
          cmd_nxt   = '0;
          len_nxt   = '0;
          cnt_nxt   = '0;
        end
      end
    endcase
    q_data.command     = cmd_nxt;
    q_data.length      = len_nxt;
    q_data.in_progress = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r     <= SYNC_RESET;
      escape_r   <= ESCAPE_RESET;
      phase_r    <= PH_IDLE;
      esc_pend_r <= 1'b0;
      cmd_r      <= '0;
      len_r      <= '0;
      cnt_r      <= '0;
    end else begin
      if (cfg.we && cfg.index == CFG_SYNC) begin
        sync_r <= cfg.wdata;
      end
      if (cfg.we && cfg.index == CFG_ESCAPE) begin
        escape_r <= cfg.wdata;
      end
      if (accept) begin
        phase_r    <= phase_nxt;
        esc_pend_r <= esc_pend_nxt;
        cmd_r      <= cmd_nxt;
        len_r      <= len_nxt;
        cnt_r      <= cnt_nxt;
      end
    end
  end

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE || phase_r == PH_CMD || phase_r == PH_LEN ||
    phase_r == PH_BODY || phase_r == PH_SUM)
    else $error("phase out of range");

  a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_data.kind == KIND_DONE) |=> (phase_r == PH_IDLE && !esc_pend_r))
    else $error("packet completion did not return to idle");

  a_body_open: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_data.kind == KIND_BODY) |-> q_data.in_progress)
    else $error("body byte outside a packet");

endmodule

`default_nettype wire

// ===== rtl/esd_queue.sv =====
`default_nettype none

module esd_queue import esd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire esd_result_t push_data,
  output logic             full,
  input  wire logic        pop,
  output logic             empty,
  output esd_result_t      head
);

  esd_result_t head_r, head_nxt;
  esd_result_t spare_r, spare_nxt;
  logic        head_v_r, head_v_nxt;
  logic        spare_v_r, spare_v_nxt;
  logic        push_ok, pop_ok;

  assign full    = spare_v_r;
  assign empty   = !head_v_r;
  assign head    = head_r;
  assign push_ok = push && !spare_v_r;
  assign pop_ok  = pop && head_v_r;

  always_comb begin
    head_nxt    = head_r;
    spare_nxt   = spare_r;
    head_v_nxt  = head_v_r;
    spare_v_nxt = spare_v_r;
    if (pop_ok) begin
      if (spare_v_r) begin
        head_nxt    = spare_r;
        spare_v_nxt = 1'b0;
      end else begin
        head_nxt   = push_data;
        head_v_nxt = push_ok;
      end
    end else if (!head_v_r) begin
      head_nxt   = push_data;
      head_v_nxt = push_ok;
    end else if (push_ok) begin
      spare_nxt   = push_data;
      spare_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    head_r  <= head_nxt;
    spare_r <= spare_nxt;
    if (!rst_n) begin
      head_v_r  <= 1'b0;
      spare_v_r <= 1'b0;
    end else begin
      head_v_r  <= head_v_nxt;
      spare_v_r <= spare_v_nxt;
    end
  end

  a_spare_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    spare_v_r |-> head_v_r)
    else $error("spare entry without head entry");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (push_ok && !head_v_r) |=> (head_v_r && head_r == $past(push_data)))
    else $error("push into empty queue lost");

  a_pop_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_ok && !spare_v_r && !push_ok) |=> !head_v_r)
    else $error("queue not empty after last pop");

endmodule

`default_nettype wire

// ===== rtl/escaped_serial_packet_deframer.sv =====
// An accepted request's result is registered in the result queue; the head entry drives the out_ ports.
// Throughput: one request per cycle while full is low; a two-entry result queue lets input continue
// for one more request while pop is held low.
// Reset (rst_n low, synchronous): sync 255, escape 253, waiting for sync,
// escape flag and packet stores cleared, result queue empty.
`default_nettype none

module escaped_serial_packet_deframer import esd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_wdata,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [BYTE_W-1:0]    in_rx_byte,
  output logic                      empty,
  input  wire logic                 pop,
  output logic [KIND_W-1:0]         out_result_kind,
  output logic [BYTE_W-1:0]         out_data_byte,
  output logic [BYTE_W-1:0]         out_byte_index,
  output logic [BYTE_W-1:0]         out_packet_command,
  output logic [BYTE_W-1:0]         out_packet_length,
  output logic [BYTE_W-1:0]         out_packet_checksum,
  output logic                      out_in_progress
);

  esd_cfg_t    cfg;
  esd_result_t q_data;
  esd_result_t head;
  logic        q_push;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.wdata = cfg_wdata;

  esd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .push    (push),
    .rx_byte (in_rx_byte),
    .q_full  (full),
    .q_push  (q_push),
    .q_data  (q_data)
  );

  esd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  assign out_result_kind     = head.kind;
  assign out_data_byte       = head.data;
  assign out_byte_index      = head.index;
  assign out_packet_command  = head.command;
  assign out_packet_length   = head.length;
  assign out_packet_checksum = head.checksum;
  assign out_in_progress     = head.in_progress;

endmodule

`default_nettype wire
